>>> rtl/pqp_pkg.sv
// Package for the process priority queue pair: payload structs, status codes,
// per-cycle cell command and sizing constants. No dependencies.
`timescale 1ns / 1ps

package pqp_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int ID_BITS     = 8;
	localparam int PRIO_BITS   = 8;
	localparam int FILL_W      = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [1:0] {
		ST_OK          = 2'd0,
		ST_NOT_FOUND   = 2'd1,
		ST_WRONG_QUEUE = 2'd2,
		ST_FULL        = 2'd3
	} status_t;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_REMOVE = 1'b1;
	localparam logic Q_READY   = 1'b0;
	localparam logic Q_BLOCKED = 1'b1;

	typedef struct packed {
		logic                        op;
		logic                        queue_sel;
		logic [ID_BITS-1:0]          entry_id;
		logic signed [PRIO_BITS-1:0] priority_req;
		logic                        by_priority;
	} req_t;

	typedef struct packed {
		status_t                     status;
		logic                        ready_head_valid;
		logic [ID_BITS-1:0]          ready_head_id;
		logic signed [PRIO_BITS-1:0] ready_head_priority;
		logic [FILL_W-1:0]           ready_count;
		logic [FILL_W-1:0]           blocked_count;
	} rsp_t;

	// Command broadcast to every cell of one row.
	typedef struct packed {
		logic                        match_id;  // hit on id match, else insert position
		logic                        ordered;
		logic                        ins_en;
		logic                        rem_en;
		logic [ID_BITS-1:0]          id;
		logic signed [PRIO_BITS-1:0] prio;
	} cell_cmd_t;

endpackage

>>> rtl/pqp_cell.sv
// One queue slot: holds an id and a priority, shifts toward either neighbor.
// Depends on pqp_pkg.
`timescale 1ns / 1ps

module pqp_cell (
	input  logic                                 clk,
	input  logic                                 valid,
	input  pqp_pkg::cell_cmd_t                   cmd,
	input  logic                                 before_in,
	output logic                                 before_out,
	input  logic [pqp_pkg::ID_BITS-1:0]          left_id,
	input  logic signed [pqp_pkg::PRIO_BITS-1:0] left_prio,
	input  logic [pqp_pkg::ID_BITS-1:0]          right_id,
	input  logic signed [pqp_pkg::PRIO_BITS-1:0] right_prio,
	output logic [pqp_pkg::ID_BITS-1:0]          id,
	output logic signed [pqp_pkg::PRIO_BITS-1:0] prio
);

	logic [pqp_pkg::ID_BITS-1:0]          id_q;
	logic signed [pqp_pkg::PRIO_BITS-1:0] prio_q;
	logic                                 hit;

	// Insert: first empty slot or, if ordered, first slot not above the new prio.
	always_comb begin
		if (cmd.match_id) begin
			hit = valid && (id_q == cmd.id);
		end else begin
			hit = !valid || (cmd.ordered && (prio_q <= cmd.prio));
		end
		before_out = before_in | hit;
	end

	always_ff @(posedge clk) begin
		if (cmd.ins_en) begin
			if (before_in) begin
				id_q   <= left_id;
				prio_q <= left_prio;
			end else if (hit) begin
				id_q   <= cmd.id;
				prio_q <= cmd.prio;
			end
		end else if (cmd.rem_en && (before_in || hit)) begin
			id_q   <= right_id;
			prio_q <= right_prio;
		end
	end

	assign id   = id_q;
	assign prio = prio_q;

endmodule

>>> rtl/pqp_row.sv
// One queue as a chain of pqp_cell slots with a first-hit chain through them.
// Depends on pqp_pkg and pqp_cell.
`timescale 1ns / 1ps

module pqp_row (
	input  logic                                 clk,
	input  logic [pqp_pkg::FILL_W-1:0]           fill,
	input  pqp_pkg::cell_cmd_t                   cmd,
	output logic                                 any_hit,
	output logic [pqp_pkg::ID_BITS-1:0]          head_id,
	output logic signed [pqp_pkg::PRIO_BITS-1:0] head_prio
);

	localparam int D = pqp_pkg::QUEUE_DEPTH;

	logic [D:0]                           hit_chain;
	logic [pqp_pkg::ID_BITS-1:0]          ids   [D];
	logic signed [pqp_pkg::PRIO_BITS-1:0] prios [D];

	assign hit_chain[0] = 1'b0;

	for (genvar i = 0; i < D; i++) begin : g_cell
		logic [pqp_pkg::ID_BITS-1:0]          l_id, r_id;
		logic signed [pqp_pkg::PRIO_BITS-1:0] l_prio, r_prio;

		if (i == 0) begin : g_first
			assign l_id   = cmd.id;
			assign l_prio = cmd.prio;
		end else begin : g_mid
			assign l_id   = ids[i-1];
			assign l_prio = prios[i-1];
		end
		if (i == D - 1) begin : g_last
			assign r_id   = ids[i];
			assign r_prio = prios[i];
		end else begin : g_inner
			assign r_id   = ids[i+1];
			assign r_prio = prios[i+1];
		end

		pqp_cell u_cell (
			.clk        (clk),
			.valid      (pqp_pkg::FILL_W'(i) < fill),
			.cmd        (cmd),
			.before_in  (hit_chain[i]),
			.before_out (hit_chain[i+1]),
			.left_id    (l_id),
			.left_prio  (l_prio),
			.right_id   (r_id),
			.right_prio (r_prio),
			.id         (ids[i]),
			.prio       (prios[i])
		);
	end

	assign any_hit   = hit_chain[D];
	assign head_id   = ids[0];
	assign head_prio = prios[0];

endmodule

>>> rtl/process_priority_queue_pair_core.sv
// Top level of the process priority queue pair: request capture, status and
// fill counters around two pqp_row cell chains. Depends on pqp_pkg, pqp_row.
`timescale 1ns / 1ps

// In the cycle after start is accepted, every slot of both queues compares against
// the request, and on a successful insert or remove the slots of the selected queue
// at and past the hit shift one place; the result appears on rsp with done high in
// the following cycle, and busy is low again then, so a new item may start alongside
// that result. A start while busy is high is not accepted, so a new item cannot
// overlap the last. The result shows the state after the item and cannot be stalled.
module process_priority_queue_pair_core (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  pqp_pkg::req_t req,
	output logic          busy,
	output logic          done,
	output pqp_pkg::rsp_t rsp
);

	localparam int D = pqp_pkg::QUEUE_DEPTH;

	pqp_pkg::req_t      req_q;
	logic               exec_q;
	logic               done_q;
	pqp_pkg::status_t   status_q;
	pqp_pkg::status_t   status_d;
	logic [pqp_pkg::FILL_W-1:0] rfill_q, bfill_q, rfill_d, bfill_d;

	pqp_pkg::cell_cmd_t rcmd, bcmd;
	logic               r_hit, b_hit;
	logic [pqp_pkg::ID_BITS-1:0]          r_head_id, b_head_id;
	logic signed [pqp_pkg::PRIO_BITS-1:0] r_head_prio, b_head_prio;
	logic [pqp_pkg::FILL_W-1:0]           sel_fill;

	always_comb begin
		rcmd.match_id = (req_q.op == pqp_pkg::OP_REMOVE);
		rcmd.ordered  = req_q.by_priority;
		rcmd.ins_en   = 1'b0;
		rcmd.rem_en   = 1'b0;
		rcmd.id       = req_q.entry_id;
		rcmd.prio     = req_q.priority_req;
		bcmd          = rcmd;
		rfill_d       = rfill_q;
		bfill_d       = bfill_q;
		status_d      = pqp_pkg::ST_OK;
		sel_fill      = (req_q.queue_sel == pqp_pkg::Q_READY) ? rfill_q : bfill_q;

		if (req_q.op == pqp_pkg::OP_INSERT) begin
			if (sel_fill == pqp_pkg::FILL_W'(D)) begin
				status_d = pqp_pkg::ST_FULL;
			end else if (req_q.queue_sel == pqp_pkg::Q_READY) begin
				rcmd.ins_en = exec_q;
				rfill_d     = rfill_q + pqp_pkg::FILL_W'(1);
			end else begin
				bcmd.ins_en = exec_q;
				bfill_d     = bfill_q + pqp_pkg::FILL_W'(1);
			end
		end else begin
			// Both queues are searched at once; a ready queue hit wins.
			if (!r_hit && !b_hit) begin
				status_d = pqp_pkg::ST_NOT_FOUND;
			end else if (r_hit != (req_q.queue_sel == pqp_pkg::Q_READY)) begin
				status_d = pqp_pkg::ST_WRONG_QUEUE;
			end else if (r_hit) begin
				rcmd.rem_en = exec_q;
				rfill_d     = rfill_q - pqp_pkg::FILL_W'(1);
			end else begin
				bcmd.rem_en = exec_q;
				bfill_d     = bfill_q - pqp_pkg::FILL_W'(1);
			end
		end
	end

	pqp_row u_ready (
		.clk       (clk),
		.fill      (rfill_q),
		.cmd       (rcmd),
		.any_hit   (r_hit),
		.head_id   (r_head_id),
		.head_prio (r_head_prio)
	);

	pqp_row u_blocked (
		.clk       (clk),
		.fill      (bfill_q),
		.cmd       (bcmd),
		.any_hit   (b_hit),
		.head_id   (b_head_id),
		.head_prio (b_head_prio)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exec_q  <= 1'b0;
			done_q  <= 1'b0;
			rfill_q <= '0;
			bfill_q <= '0;
		end else begin
			exec_q <= start && !exec_q;
			done_q <= exec_q;
			if (exec_q) begin
				rfill_q <= rfill_d;
				bfill_q <= bfill_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !exec_q) begin
			req_q <= req;
		end
		if (exec_q) begin
			status_q <= status_d;
		end
	end

	assign busy = exec_q;
	assign done = done_q;

	always_comb begin
		rsp.status              = status_q;
		rsp.ready_head_valid    = (rfill_q != '0);
		rsp.ready_head_id       = (rfill_q != '0) ? r_head_id : '0;
		rsp.ready_head_priority = (rfill_q != '0) ? r_head_prio : '0;
		rsp.ready_count         = rfill_q;
		rsp.blocked_count       = bfill_q;
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(rfill_q <= pqp_pkg::FILL_W'(D)) && (bfill_q <= pqp_pkg::FILL_W'(D)))
		else $error("queue fill count beyond depth");

	// Blocked head is not reported; a non-empty blocked queue must still hold a known head.
	a_blocked_head: assert property (@(posedge clk) disable iff (!arst_n)
		(bfill_q == '0) || !$isunknown({b_head_id, b_head_prio}))
		else $error("blocked queue head unknown while not empty");

	a_fill_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!exec_q |=> $stable(rfill_q) && $stable(bfill_q))
		else $error("fill count changed outside the execute cycle");

	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		exec_q |=> done_q && !exec_q)
		else $error("result strobe did not follow the execute cycle");

	a_full_drop: assert property (@(posedge clk) disable iff (!arst_n)
		exec_q && (status_d == pqp_pkg::ST_FULL) |=> $stable(rfill_q) && $stable(bfill_q))
		else $error("insert into a full queue changed a count");

endmodule

>>> bench/tb_process_priority_queue_pair_core.sv
// Self-checking bench for process_priority_queue_pair_core: a directed table,
// then random ready/blocked queue traffic, checked against a scoreboard model.
// Depends on pqp_pkg and process_priority_queue_pair_core.
`timescale 1ns / 1ps

module tb_process_priority_queue_pair_core;
	import pqp_pkg::*;

	localparam int RANDOM_ITEMS = 700;

	typedef struct {
		req_t op_req;
		bit   typed;
		rsp_t want;
	} sched_row_t;

	logic  clk    = 1'b0;
	logic  arst_n = 1'b0;
	logic  start  = 1'b0;
	req_t  req    = '0;
	logic  busy;
	logic  done;
	rsp_t  rsp;

	// Scoreboard copy of both queues: index Q_READY and Q_BLOCKED
	logic [ID_BITS-1:0]          slot_id   [2][QUEUE_DEPTH];
	logic signed [PRIO_BITS-1:0] slot_prio [2][QUEUE_DEPTH];
	int                          slot_fill [2] = '{0, 0};

	rsp_t       pending_views[$];
	sched_row_t sched_table[$];
	int         mismatches   = 0;
	int         items_sent   = 0;
	int         results_seen = 0;
	int         empty_heads  = 0;
	int         status_tally[4] = '{0, 0, 0, 0};
	bit         gaps_on      = 1'b1;

	process_priority_queue_pair_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.req    (req),
		.busy   (busy),
		.done   (done),
		.rsp    (rsp)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic req_t mk_req(logic op, logic sel, logic [ID_BITS-1:0] id,
			logic signed [PRIO_BITS-1:0] prio, logic ordered);
		req_t r;
		r.op           = op;
		r.queue_sel    = sel;
		r.entry_id     = id;
		r.priority_req = prio;
		r.by_priority  = ordered;
		return r;
	endfunction

	function automatic rsp_t mk_rsp(status_t s, logic head_valid, logic [ID_BITS-1:0] id,
			logic signed [PRIO_BITS-1:0] prio, int ready_n, int blocked_n);
		rsp_t v;
		v.status              = s;
		v.ready_head_valid    = head_valid;
		v.ready_head_id       = id;
		v.ready_head_priority = prio;
		v.ready_count         = FILL_W'(ready_n);
		v.blocked_count       = FILL_W'(blocked_n);
		return v;
	endfunction

	function automatic int find_id(int q, logic [ID_BITS-1:0] id);
		int hit;
		hit = -1;
		for (int i = 0; i < slot_fill[q]; i++) begin
			if (hit < 0 && slot_id[q][i] == id)
				hit = i;
		end
		return hit;
	endfunction

	// Apply one operation to the scoreboard queues and return the view it leaves.
	function automatic rsp_t apply_sched_op(req_t r);
		rsp_t    v;
		int      q;
		int      pos;
		int      at;
		bit      placed;
		status_t s;
		q = int'(r.queue_sel);
		if (r.op == OP_INSERT) begin
			if (slot_fill[q] >= QUEUE_DEPTH) begin
				s = ST_FULL;
			end else begin
				pos    = slot_fill[q];
				placed = 1'b0;
				if (r.by_priority) begin
					// land ahead of the first entry of equal or lower priority
					for (int i = 0; i < slot_fill[q]; i++) begin
						if (!placed && slot_prio[q][i] <= r.priority_req) begin
							pos    = i;
							placed = 1'b1;
						end
					end
				end
				for (int i = slot_fill[q]; i > pos; i--) begin
					slot_id[q][i]   = slot_id[q][i-1];
					slot_prio[q][i] = slot_prio[q][i-1];
				end
				slot_id[q][pos]   = r.entry_id;
				slot_prio[q][pos] = r.priority_req;
				slot_fill[q]++;
				s = ST_OK;
			end
		end else begin
			// first match wins, ready queue searched before blocked queue
			q  = int'(Q_READY);
			at = find_id(q, r.entry_id);
			if (at < 0) begin
				q  = int'(Q_BLOCKED);
				at = find_id(q, r.entry_id);
			end
			if (at < 0) begin
				s = ST_NOT_FOUND;
			end else if (q != int'(r.queue_sel)) begin
				s = ST_WRONG_QUEUE;
			end else begin
				for (int i = at; i + 1 < slot_fill[q]; i++) begin
					slot_id[q][i]   = slot_id[q][i+1];
					slot_prio[q][i] = slot_prio[q][i+1];
				end
				slot_fill[q]--;
				s = ST_OK;
			end
		end
		if (slot_fill[Q_READY] > 0)
			v = mk_rsp(s, 1'b1, slot_id[Q_READY][0], slot_prio[Q_READY][0],
				slot_fill[Q_READY], slot_fill[Q_BLOCKED]);
		else
			v = mk_rsp(s, 1'b0, '0, '0, 0, slot_fill[Q_BLOCKED]);
		return v;
	endfunction

	function automatic req_t random_sched_op(int n);
		req_t r;
		int   ins_pct;
		// alternate insert-heavy and remove-heavy stretches to sweep full and empty
		case ((n / 80) % 4)
			0: begin
				ins_pct = 80;
			end
			1: begin
				ins_pct = 25;
			end
			2: begin
				ins_pct = 60;
			end
			default: begin
				ins_pct = 15;
			end
		endcase
		r.op        = ($urandom_range(99) < ins_pct) ? OP_INSERT : OP_REMOVE;
		r.queue_sel = $urandom_range(1) ? Q_BLOCKED : Q_READY;
		// small id pool so removes hit, duplicates and cross-queue matches happen
		r.entry_id  = ($urandom_range(7) == 0) ? ID_BITS'($urandom) : ID_BITS'($urandom_range(23));
		// narrow priorities give many ties
		r.priority_req = ($urandom_range(3) == 0) ? PRIO_BITS'($urandom)
			: PRIO_BITS'($urandom_range(6) - 3);
		r.by_priority  = 1'($urandom_range(1));
		return r;
	endfunction

	task automatic add_row(req_t r, bit typed, rsp_t want);
		sched_row_t row;
		row.op_req = r;
		row.typed  = typed;
		row.want   = want;
		sched_table.push_back(row);
	endtask

	// Present one item from a falling edge, hold it until accepted, return at a falling edge.
	task automatic issue(req_t r, bit typed, rsp_t want);
		rsp_t model_view;
		while (gaps_on && $urandom_range(99) < 6) begin
			start = 1'b0;
			@(negedge clk);
		end
		start = 1'b1;
		req   = r;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		model_view = apply_sched_op(r);
		pending_views.push_back(typed ? want : model_view);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic drain_results();
		start = 1'b0;
		while (pending_views.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic note_mismatch(string what, logic [63:0] want_v, logic [63:0] got_v);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch: %s at %0t ns, expected 0x%0h, got 0x%0h",
				what, $time, want_v, got_v);
	endtask

	always @(posedge clk) begin : check_results
		rsp_t want;
		if (arst_n && done) begin
			results_seen++;
			if (pending_views.size() == 0) begin
				note_mismatch("result with nothing outstanding", '0, rsp);
			end else begin
				want = pending_views.pop_front();
				status_tally[int'(want.status)]++;
				if (!want.ready_head_valid)
					empty_heads++;
				if (rsp.status !== want.status)
					note_mismatch("status", want.status, rsp.status);
				if (rsp.ready_head_valid !== want.ready_head_valid)
					note_mismatch("ready_head_valid", want.ready_head_valid,
						rsp.ready_head_valid);
				if (rsp.ready_head_id !== want.ready_head_id)
					note_mismatch("ready_head_id", want.ready_head_id, rsp.ready_head_id);
				if (rsp.ready_head_priority !== want.ready_head_priority)
					note_mismatch("ready_head_priority", want.ready_head_priority,
						rsp.ready_head_priority);
				if (rsp.ready_count !== want.ready_count)
					note_mismatch("ready_count", want.ready_count, rsp.ready_count);
				if (rsp.blocked_count !== want.blocked_count)
					note_mismatch("blocked_count", want.blocked_count, rsp.blocked_count);
			end
		end
	end

	initial begin
		// empty queues, extremes, tie ordering, cross-queue match and duplicates
		add_row(mk_req(OP_REMOVE, Q_READY, 8'h05, -8'sd1, 1'b0), 1'b1,
			mk_rsp(ST_NOT_FOUND, 1'b0, 8'h00, 8'sd0, 0, 0));
		add_row(mk_req(OP_INSERT, Q_READY, 8'hff, 8'sd127, 1'b0), 1'b1,
			mk_rsp(ST_OK, 1'b1, 8'hff, 8'sd127, 1, 0));
		add_row(mk_req(OP_INSERT, Q_READY, 8'h00, -8'sd128, 1'b1), 1'b1,
			mk_rsp(ST_OK, 1'b1, 8'hff, 8'sd127, 2, 0));
		add_row(mk_req(OP_INSERT, Q_READY, 8'h03, 8'sd127, 1'b1), 1'b1,
			mk_rsp(ST_OK, 1'b1, 8'h03, 8'sd127, 3, 0));
		add_row(mk_req(OP_INSERT, Q_BLOCKED, 8'h00, 8'sd5, 1'b0), 1'b1,
			mk_rsp(ST_OK, 1'b1, 8'h03, 8'sd127, 3, 1));
		add_row(mk_req(OP_REMOVE, Q_BLOCKED, 8'h00, 8'sd127, 1'b1), 1'b1,
			mk_rsp(ST_WRONG_QUEUE, 1'b1, 8'h03, 8'sd127, 3, 1));
		add_row(mk_req(OP_REMOVE, Q_READY, 8'h00, -8'sd128, 1'b0), 1'b1,
			mk_rsp(ST_OK, 1'b1, 8'h03, 8'sd127, 2, 1));
		add_row(mk_req(OP_REMOVE, Q_BLOCKED, 8'h00, 8'sd0, 1'b0), 1'b1,
			mk_rsp(ST_OK, 1'b1, 8'h03, 8'sd127, 2, 0));
		add_row(mk_req(OP_REMOVE, Q_READY, 8'h03, 8'sd1, 1'b1), 1'b1,
			mk_rsp(ST_OK, 1'b1, 8'hff, 8'sd127, 1, 0));
		add_row(mk_req(OP_INSERT, Q_BLOCKED, 8'hff, -8'sd128, 1'b1), 1'b1,
			mk_rsp(ST_OK, 1'b1, 8'hff, 8'sd127, 1, 1));
		add_row(mk_req(OP_REMOVE, Q_BLOCKED, 8'hff, 8'sd0, 1'b0), 1'b1,
			mk_rsp(ST_WRONG_QUEUE, 1'b1, 8'hff, 8'sd127, 1, 1));
		// fill the ready queue with mixed tail and ordered inserts, then overflow it
		for (int i = 0; i < QUEUE_DEPTH - 1; i++)
			add_row(mk_req(OP_INSERT, Q_READY, ID_BITS'(8'h40 + i), PRIO_BITS'(i * 37 - 100),
				1'(i)), 1'b0, '0);
		add_row(mk_req(OP_INSERT, Q_READY, 8'h80, 8'sd0, 1'b1), 1'b0, '0);

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (sched_table[i])
			issue(sched_table[i].op_req, sched_table[i].typed, sched_table[i].want);
		drain_results();

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			// hold off until the block has reported everything
			if (n == RANDOM_ITEMS / 2)
				drain_results();
			gaps_on = !(n >= 400 && n < 550);
			issue(random_sched_op(n), 1'b0, '0);
		end
		drain_results();
		repeat (4) @(posedge clk);

		$display("%0d items, %0d results: ok %0d, id absent %0d, other queue %0d, full %0d",
			items_sent, results_seen, status_tally[ST_OK], status_tally[ST_NOT_FOUND],
			status_tally[ST_WRONG_QUEUE], status_tally[ST_FULL]);
		$display("%0d results with an empty ready queue, %0d mismatches",
			empty_heads, mismatches);
		if (mismatches == 0 && pending_views.size() == 0)
			$display("tb_process_priority_queue_pair_core OK");
		else
			$display("tb_process_priority_queue_pair_core NOT OK");
		$finish;
	end

	initial begin
		#2000000;
		$display("timeout with %0d results outstanding", pending_views.size());
		$display("tb_process_priority_queue_pair_core NOT OK");
		$finish;
	end

endmodule

>>> process_priority_queue_pair_core.f
rtl/pqp_pkg.sv
rtl/pqp_cell.sv
rtl/pqp_row.sv
rtl/process_priority_queue_pair_core.sv
bench/tb_process_priority_queue_pair_core.sv
